/* rtl/button_press_classifier_defines.svh */
// assertion macros for the button press classifier checker
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define BPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
// types and constants shared by the button press classifier
package bpc_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DEB_W      = 10;
  localparam int WIN_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd2;

  localparam logic [DEB_W-1:0] DEBOUNCE_RST = 10'd50;
  localparam logic [WIN_W-1:0] GAP_RST      = 16'd500;
  localparam logic [WIN_W-1:0] LONG_RST     = 16'd2000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_HELD,
    PH_LONG,
    PH_GAP
  } phase_t;

  typedef enum logic [1:0] {
    EV_SINGLE,
    EV_DOUBLE,
    EV_LONG
  } event_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [WIN_W-1:0] gap_window_ticks;
    logic [WIN_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic   fire;
    event_t code;
  } res_t;

endpackage

/* rtl/bpc_in_if.sv */
// input channel: one tick with the raw button level
interface bpc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

/* rtl/bpc_out_if.sv */
// result channel: one classified gesture
interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

/* rtl/bpc_core.sv */
// gesture state machine: debounce, hold, gap window and tally
module bpc_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic          pin_level,
  input  bpc_pkg::cfg_t cfg,
  output bpc_pkg::res_t res
);
  import bpc_pkg::*;

  localparam int LW = (TIMER_WIDTH > WIN_W) ? TIMER_WIDTH : WIN_W;
  localparam logic [LW-1:0] TMAX = LW'({TIMER_WIDTH{1'b1}});

  phase_t                 phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt, timer_sat;
  logic [1:0]             tally_r, tally_nxt;
  logic                   prev_r, prev_nxt;
  logic                   press_edge;
  logic [LW-1:0]          lim_deb, lim_gap, lim_long, timer_ext;

  // limits wider than the timer are clamped so every window ends
  always_comb begin
    lim_deb  = (LW'(cfg.debounce_ticks) > TMAX) ? TMAX : LW'(cfg.debounce_ticks);
    lim_gap  = (LW'(cfg.gap_window_ticks) > TMAX) ? TMAX : LW'(cfg.gap_window_ticks);
    lim_long = (LW'(cfg.long_press_ticks) > TMAX) ? TMAX : LW'(cfg.long_press_ticks);
  end

  assign timer_sat  = (timer_r == '1) ? timer_r : timer_r + TIMER_WIDTH'(1);
  assign timer_ext  = LW'(timer_sat);
  assign press_edge = prev_r && !pin_level;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    tally_nxt = tally_r;
    prev_nxt  = pin_level;
    res.fire  = 1'b0;
    res.code  = EV_SINGLE;
    case (phase_r)
      PH_IDLE, PH_GAP: begin
        if (press_edge) begin
          timer_nxt = '0;
          // zero debounce confirms on the edge itself; the pin is low there
          phase_nxt = (cfg.debounce_ticks == '0) ? PH_HELD : PH_DEBOUNCE;
        end else if (phase_r == PH_GAP) begin
          timer_nxt = timer_sat;
          if (timer_ext >= lim_gap) begin
            res.fire  = 1'b1;
            res.code  = (tally_r >= 2'd2) ? EV_DOUBLE : EV_SINGLE;
            tally_nxt = '0;
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
          end
        end
      end
      PH_DEBOUNCE: begin
        timer_nxt = timer_sat;
        if (timer_ext >= lim_deb) begin
          timer_nxt = '0;
          if (!pin_level) begin
            phase_nxt = PH_HELD;
          end else begin
            // bounce: back to the window if presses are pending
            phase_nxt = (tally_r != '0) ? PH_GAP : PH_IDLE;
          end
        end
      end
      PH_HELD: begin
        if (pin_level) begin
          if (tally_r != 2'd3) begin
            tally_nxt = tally_r + 2'd1;
          end
          phase_nxt = PH_GAP;
          timer_nxt = '0;
        end else begin
          timer_nxt = timer_sat;
          if (timer_ext > lim_long || timer_sat == '1) begin
            res.fire  = 1'b1;
            res.code  = EV_LONG;
            tally_nxt = '0;
            phase_nxt = PH_LONG;
            timer_nxt = '0;
          end
        end
      end
      PH_LONG: begin
        if (pin_level) begin
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        timer_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      tally_r <= '0;
      prev_r  <= 1'b1;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      tally_r <= tally_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

/* rtl/button_press_classifier.sv */
// button press classifier top level: config registers and result register
//
//  channel   dir  payload            beat
//  in_ch     in   pin_level (1b)     one tick of the raw active-low pin
//  out_ch    out  event_code (2b)    0 single, 1 double, 2 long press
//  cfg_*     in   index 2b, data 16b write on cfg_we, no read-back
//
// one tick per cycle while in_ch.ready is high: the state update is a timer increment
// and limit compares between the state registers and the result register.
// in_ch.ready is low only while a result sits unclaimed and out_ch.ready is low.
// rst_n is synchronous; it clears the state, the result valid and loads the
// default limits 50, 500 and 2000.
module button_press_classifier #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bpc_in_if.sink                         in_ch,
  bpc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bpc_pkg::*;

  cfg_t   cfg_r;
  res_t   res;
  logic   step;
  logic   out_valid_r, out_valid_nxt;
  event_t out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.gap_window_ticks <= GAP_RST;
      cfg_r.long_press_ticks <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: cfg_r.debounce_ticks   <= cfg_wdata[DEB_W-1:0];
        CFG_GAP:      cfg_r.gap_window_ticks <= cfg_wdata[WIN_W-1:0];
        CFG_LONG:     cfg_r.long_press_ticks <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  bpc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .pin_level (in_ch.pin_level),
    .cfg       (cfg_r),
    .res       (res)
  );

  // a beat taken here always frees the result slot first
  assign out_valid_nxt = step ? res.fire : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.fire) begin
      out_code_r <= res.code;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = out_code_r;

endmodule

/* rtl/bpc_checker.sv */
// port-level checks for the button press classifier, bound to the top level
`include "button_press_classifier_defines.svh"

module bpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_code
);
  import bpc_pkg::*;

  `BPC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_code), "stalled result changed")
  `BPC_ASSERT_IMP(a_code_legal, out_valid, out_code != 2'd3, "illegal event code")
  `BPC_ASSERT_IMP(a_ready_free, !out_valid, in_ready, "input stalled with empty result slot")
  `BPC_ASSERT_IMP(a_cause, $rose(out_valid), $past(in_valid && in_ready), "result without input beat")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_code  (out_ch.event_code)
);
